>>> design/watm_pkg.sv
// Shared types, constants and helpers for the weekly alarm table matcher.
`timescale 1ns / 1ps
package watm_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [7:0] ANY_DAY   = 8'h80;
  localparam logic [7:0] WEEK_MASK = 8'h7F;
  localparam logic [1:0] SNZ_FULL  = 2'h3;
  localparam logic [1:0] SNZ_DUE   = 2'h1;
  localparam logic [7:0] HOURS     = 8'd24;
  localparam logic [7:0] MINUTES   = 8'd60;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_EDIT  = 3'd1,
    OP_DEL   = 3'd2,
    OP_TICK  = 3'd3,
    OP_STOP  = 3'd4,
    OP_CLEAR = 3'd5
  } op_t;

  typedef struct packed {
    logic [7:0] id;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] days;
    logic       on;
  } entry_t;

  typedef struct packed {
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] days;
    logic [7:0] old_hour;
    logic [7:0] old_minute;
    logic [7:0] old_days;
    logic [2:0] weekday;
  } req_t;

  typedef struct packed {
    logic old_eq;
    logic clash;
    logic fire;
  } cmp_t;

  // weekday 0 is Sunday (mask bit 6); 7 has no bit
  function automatic logic [7:0] day_bit(input logic [2:0] wd);
    logic [7:0] b;
    case (wd)
      3'd0:    b = 8'h40;
      3'd1:    b = 8'h01;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h04;
      3'd4:    b = 8'h08;
      3'd5:    b = 8'h10;
      3'd6:    b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> design/watm_cmp.sv
// Shared compare unit: one table entry against the pending request.
`timescale 1ns / 1ps
module watm_cmp import watm_pkg::*; (
  input  entry_t ent,
  input  req_t   req,
  output cmp_t   res
);

  logic time_eq;

  assign time_eq = ({3'b0, ent.hour} == req.hour) && ({2'b0, ent.minute} == req.minute);

  always_comb begin
    res.old_eq = ({3'b0, ent.hour} == req.old_hour) &&
                 ({2'b0, ent.minute} == req.old_minute) && (ent.days == req.old_days);
    res.clash  = time_eq && (((req.days & ent.days) & WEEK_MASK) != 8'h00);
    res.fire   = ent.on && time_eq &&
                 ((ent.days == ANY_DAY) || ((ent.days & day_bit(req.weekday)) != 8'h00));
  end

endmodule

>>> design/weekly_alarm_table_matcher.sv
// Top level: alarm table with add/edit/delete, minute tick and snooze handling.
`timescale 1ns / 1ps
// One request is taken at a time. in_tready is high only while the block is
// idle; a request then walks the held entries one per cycle through a single
// shared compare unit, applies the outcome in the apply state and presents
// its response on the out_ channel until taken. Add, edit, delete and tick
// walk all count_held entries (0..16), or none on an empty table; stop
// snooze, clear all and unused codes go straight to the apply state. The next
// request is accepted the cycle after the response is taken. The entry
// fields live in flip-flop arrays with one read port (the walk pointer) and
// one write port; slots beyond count_held are never read, so they need no
// clearing at reset or on clear all.
module weekly_alarm_table_matcher import watm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] entry_id, [15:8] hour, [23:16] minute, [31:24] day_mask, [32] enable,
  // [40:33] old_hour, [48:41] old_minute, [56:49] old_day_mask, [59:57] weekday
  input  logic [63:0] in_tdata,
  // [2:0] func
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] ok, [4:1] hit_index, [12:5] hit_id, [17:13] entry_count
  output logic [23:0] out_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // entry storage
  entry_t     ent_mem [ENTRIES];
  logic [1:0] snz_mem [ENTRIES];

  // latched request
  logic [2:0] op_r;
  logic [7:0] id_r;
  logic       en_r;
  req_t       req_r;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] wptr_r, wptr_nxt;   // delete: next packed position
  logic [3:0]       last_hit_r, last_hit_nxt;
  logic             found_r, found_nxt;  // edit: old entry seen
  logic [IDX_W-1:0] tgt_r, tgt_nxt;      // edit target / tick hit position
  logic             clash_r, clash_nxt;
  logic             prim_r, prim_nxt;    // tick: primary alarm found
  logic             hit_r, hit_nxt;      // tick: something fired
  logic [7:0]       hid_r, hid_nxt;

  logic        ok_r, ok_nxt;
  logic [3:0]  oidx_r, oidx_nxt;
  logic [7:0]  oid_r, oid_nxt;

  // write ports
  logic             ent_we, snz_we;
  logic [IDX_W-1:0] ent_wa, snz_wa;
  entry_t           ent_wd;
  logic [1:0]       snz_wd;

  entry_t     rd_ent;
  logic [1:0] rd_snz, snz_dec;
  cmp_t       cmp;
  entry_t     new_ent;
  logic       time_ok, last_step;

  assign rd_ent = ent_mem[idx_r];
  assign rd_snz = snz_mem[idx_r];

  watm_cmp u_cmp (
    .ent (rd_ent),
    .req (req_r),
    .res (cmp)
  );

  assign snz_dec   = (rd_snz != 2'd0) ? rd_snz - 2'd1 : rd_snz;
  assign last_step = ({1'b0, idx_r} + {{(CNT_W-1){1'b0}}, 1'b1}) == cnt_r;
  assign time_ok   = (req_r.hour < HOURS) && (req_r.minute < MINUTES);

  always_comb begin
    new_ent.id     = id_r;
    new_ent.hour   = req_r.hour[4:0];
    new_ent.minute = req_r.minute[5:0];
    new_ent.days   = req_r.days;
    new_ent.on     = en_r;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {6'b0, cnt_r, oid_r, oidx_r, ok_r};

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    wptr_nxt     = wptr_r;
    last_hit_nxt = last_hit_r;
    found_nxt    = found_r;
    tgt_nxt      = tgt_r;
    clash_nxt    = clash_r;
    prim_nxt     = prim_r;
    hit_nxt      = hit_r;
    hid_nxt      = hid_r;
    ok_nxt       = ok_r;
    oidx_nxt     = oidx_r;
    oid_nxt      = oid_r;
    ent_we       = 1'b0;
    ent_wa       = idx_r;
    ent_wd       = rd_ent;
    snz_we       = 1'b0;
    snz_wa       = idx_r;
    snz_wd       = snz_dec;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          idx_nxt   = '0;
          wptr_nxt  = '0;
          found_nxt = 1'b0;
          clash_nxt = 1'b0;
          prim_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          state_nxt = ((in_tuser inside {OP_ADD, OP_EDIT, OP_DEL, OP_TICK}) &&
                       (cnt_r != '0)) ? ST_SCAN : ST_FIN;
        end
      end

      ST_SCAN: begin
        case (op_r)
          OP_ADD: begin
            if (cmp.clash) clash_nxt = 1'b1;
          end
          OP_EDIT: begin
            if (cmp.old_eq && !found_r) begin
              found_nxt = 1'b1;
              tgt_nxt   = idx_r;
            end
            if (!cmp.old_eq && cmp.clash) clash_nxt = 1'b1;
          end
          OP_DEL: begin
            // survivors move down to the packed position
            if (!cmp.old_eq) begin
              ent_we   = 1'b1;
              ent_wa   = wptr_r[IDX_W-1:0];
              ent_wd   = rd_ent;
              snz_we   = 1'b1;
              snz_wa   = wptr_r[IDX_W-1:0];
              snz_wd   = rd_snz;
              wptr_nxt = wptr_r + {{(CNT_W-1){1'b0}}, 1'b1};
            end
          end
          OP_TICK: begin
            snz_we = 1'b1;
            snz_wd = snz_dec;
            if (!prim_r && cmp.fire) begin
              snz_wd   = SNZ_FULL;
              prim_nxt = 1'b1;
              hit_nxt  = 1'b1;
              tgt_nxt  = idx_r;
              hid_nxt  = rd_ent.id;
            end else if (!prim_r && (snz_dec == SNZ_DUE) && rd_ent.on) begin
              // due snooze; a later one overrides
              snz_wd  = 2'd0;
              hit_nxt = 1'b1;
              tgt_nxt = idx_r;
              hid_nxt = rd_ent.id;
            end
          end
          default: ;
        endcase
        if (last_step) state_nxt = ST_FIN;
        else           idx_nxt   = idx_r + {{(IDX_W-1){1'b0}}, 1'b1};
      end

      ST_FIN: begin
        ok_nxt    = 1'b0;
        oidx_nxt  = 4'd0;
        oid_nxt   = 8'd0;
        state_nxt = ST_OUT;
        case (op_r)
          OP_ADD: begin
            if ((cnt_r < CNT_W'(ENTRIES)) && time_ok && !clash_r) begin
              ent_we  = 1'b1;
              ent_wa  = cnt_r[IDX_W-1:0];
              ent_wd  = new_ent;
              snz_we  = 1'b1;
              snz_wa  = cnt_r[IDX_W-1:0];
              snz_wd  = 2'd0;
              cnt_nxt = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
              ok_nxt  = 1'b1;
            end
          end
          OP_EDIT: begin
            if (found_r && time_ok && !clash_r) begin
              ent_we = 1'b1;
              ent_wa = tgt_r;
              ent_wd = new_ent;
              ok_nxt = 1'b1;
            end
          end
          OP_DEL: begin
            if (wptr_r < cnt_r) begin
              cnt_nxt = wptr_r;
              ok_nxt  = 1'b1;
            end
          end
          OP_TICK: begin
            if (hit_r) begin
              last_hit_nxt = 4'(tgt_r);
              ok_nxt       = 1'b1;
              oidx_nxt     = 4'(tgt_r);
              oid_nxt      = hid_r;
            end
          end
          OP_STOP: begin
            snz_we = 1'b1;
            snz_wa = IDX_W'(last_hit_r);
            snz_wd = 2'd0;
            ok_nxt = 1'b1;
          end
          OP_CLEAR: begin
            cnt_nxt = '0;
            ok_nxt  = 1'b1;
          end
          default: ;
        endcase
      end

      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      last_hit_r <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      last_hit_r <= last_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    wptr_r  <= wptr_nxt;
    found_r <= found_nxt;
    tgt_r   <= tgt_nxt;
    clash_r <= clash_nxt;
    prim_r  <= prim_nxt;
    hit_r   <= hit_nxt;
    hid_r   <= hid_nxt;
    ok_r    <= ok_nxt;
    oidx_r  <= oidx_nxt;
    oid_r   <= oid_nxt;
    if (in_tvalid && in_tready) begin
      op_r             <= in_tuser;
      id_r             <= in_tdata[7:0];
      req_r.hour       <= in_tdata[15:8];
      req_r.minute     <= in_tdata[23:16];
      req_r.days       <= in_tdata[31:24];
      en_r             <= in_tdata[32];
      req_r.old_hour   <= in_tdata[40:33];
      req_r.old_minute <= in_tdata[48:41];
      req_r.old_days   <= in_tdata[56:49];
      req_r.weekday    <= in_tdata[59:57];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (snz_we) snz_mem[snz_wa] <= snz_wd;
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ENTRIES)) else $error("entry count beyond table size");

  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> out_tvalid) else $error("response not presented after apply");

  a_count_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(cnt_r)) else $error("count changed during walk");

  a_held_response: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && !in_tready))
    else $error("response dropped while stalled");

endmodule
